/* rtl/assert_macros.svh */
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AVL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AVL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/avl_pkg.sv */
// Package for the voice channel allocator: sizes, types and sequencer states.
`default_nettype none

package avl_pkg;

  localparam int NUM_VOICES = 4;
  localparam int BUSY_BITS  = 4;
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int BUSY_IDX_W = (BUSY_BITS > 1) ? $clog2(BUSY_BITS) : 1;
  localparam int ID_W       = 16;
  localparam int PRIO_W     = 8;
  localparam int CH_W       = 3;

  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [ID_W-1:0]   sound_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_FREE,
    ST_LRU,
    ST_DONE
  } st_t;

  // Control of the LRU list: shift one entry down or place the chosen channel at the tail.
  typedef struct packed {
    logic  shift_en;
    logic  put_en;
    vidx_t pos;
    vidx_t pick;
  } lru_ctrl_t;

  // Write port of the voice store.
  typedef struct packed {
    logic   en;
    vidx_t  idx;
    sound_t data;
  } voice_wr_t;

endpackage

`default_nettype wire

/* rtl/avl_voice_store.sv */
// Per-channel sound id store with one write port and one indexed read.
`default_nettype none

module avl_voice_store
  import avl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire voice_wr_t wr,
  input  wire vidx_t     rd_idx,
  output sound_t         rd_data
);

  sound_t voice [NUM_VOICES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) voice[i] <= '0;
    end else if (wr.en) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        if (wr.idx == VIDX_W'(i)) voice[i] <= wr.data;
      end
    end
  end

  assign rd_data = voice[rd_idx];

endmodule

`default_nettype wire

/* rtl/avl_lru_list.sv */
// LRU order list, least recent first, updated one position per cycle.
`default_nettype none

module avl_lru_list
  import avl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire lru_ctrl_t ctrl,
  output vidx_t          rd_data,
  output vidx_t          head
);

  vidx_t order [NUM_VOICES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) order[i] <= VIDX_W'(i);
    end else begin
      // pull the next entry down over the position being closed up
      for (int i = 0; i < NUM_VOICES - 1; i++) begin
        if (ctrl.shift_en && ctrl.pos == VIDX_W'(i)) order[i] <= order[i + 1];
      end
      if (ctrl.put_en) order[NUM_VOICES - 1] <= ctrl.pick;
    end
  end

  assign rd_data = order[ctrl.pos];
  assign head    = order[0];

endmodule

`default_nettype wire

/* rtl/lru_voice_channel_allocator.sv */
// Top level of the LRU voice channel allocator: sequencer, shared comparator, result register.
//
// Input channel (in_valid/in_ready): sound_id, channel_busy, priority_req. A transaction
// with sound_id zero is absorbed while idle and gives no result.
// Output channel (out_valid/out_ready): channel (index plus one), sound_out, priority_out.
// One shared 16-bit equality comparator is stepped by a sequencer, one channel per cycle:
//   match scan  - compare each stored id with the request, stop at the first hit;
//   free scan   - only if nothing matched, walk the busy bits for the first idle channel,
//                 falling back to the head of the LRU list;
//   LRU update  - compare each LRU position with the chosen channel and close it up,
//                 then write the chosen channel at the tail;
//   done        - store the id and load the result register.
// in_ready is low while a request moves through the scans and the done step.
// The result register holds a finished result while the receiver stalls and the block
// takes the next request meanwhile; the done step waits only if the register is still full.
// Reset (rst, synchronous) clears all stored ids, restores the LRU order 0,1,2,3 and
// drops any pending result.
`default_nettype none

module lru_voice_channel_allocator
  import avl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [ID_W-1:0]   sound_id,
  input  wire logic [3:0]        channel_busy,
  input  wire logic [PRIO_W-1:0] priority_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CH_W-1:0]        channel,
  output logic [ID_W-1:0]        sound_out,
  output logic [PRIO_W-1:0]      priority_out
);

  `include "assert_macros.svh"

  localparam vidx_t LAST_IDX = VIDX_W'(NUM_VOICES - 1);

  st_t                   state, state_next;
  vidx_t                 idx, idx_next;
  vidx_t                 pick, pick_next;
  logic                  found, found_next;
  sound_t                id_q;
  logic [BUSY_BITS-1:0]  busy_q;
  logic [PRIO_W-1:0]     prio_q;
  logic                  out_valid_next;
  logic                  load_out;

  lru_ctrl_t             lru_ctrl;
  voice_wr_t             voice_wr;
  vidx_t                 lru_rd, lru_head;
  sound_t                voice_rd;

  sound_t                cmp_a, cmp_b;
  logic                  cmp_eq;
  logic [VIDX_W+BUSY_IDX_W-1:0] idx_ext;
  logic                  idx_busy;
  logic                  accept;

  avl_voice_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (voice_wr),
    .rd_idx  (idx),
    .rd_data (voice_rd)
  );

  avl_lru_list u_lru (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (lru_ctrl),
    .rd_data (lru_rd),
    .head    (lru_head)
  );

  // shared comparator: stored id against request, or LRU entry against chosen channel
  always_comb begin
    if (state == ST_LRU) begin
      cmp_a = ID_W'(lru_rd);
      cmp_b = ID_W'(pick);
    end else begin
      cmp_a = voice_rd;
      cmp_b = id_q;
    end
    cmp_eq = (cmp_a == cmp_b);
  end

  // channels beyond the busy bits count as idle
  always_comb begin
    idx_ext  = (VIDX_W + BUSY_IDX_W)'(idx);
    idx_busy = (idx_ext < (VIDX_W + BUSY_IDX_W)'(BUSY_BITS)) ?
               busy_q[idx_ext[BUSY_IDX_W-1:0]] : 1'b0;
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    pick_next        = pick;
    found_next       = found;
    load_out         = 1'b0;
    out_valid_next   = out_valid && !out_ready;
    lru_ctrl.shift_en = 1'b0;
    lru_ctrl.put_en   = 1'b0;
    lru_ctrl.pos      = idx;
    lru_ctrl.pick     = pick;
    voice_wr.en       = 1'b0;
    voice_wr.idx      = pick;
    voice_wr.data     = id_q;

    unique case (state)
      ST_IDLE: begin
        if (accept && sound_id != '0) begin
          state_next = ST_MATCH;
          idx_next   = '0;
        end
      end
      ST_MATCH: begin
        if (cmp_eq) begin
          pick_next  = idx;
          idx_next   = '0;
          found_next = 1'b0;
          state_next = ST_LRU;
        end else if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = ST_FREE;
        end else begin
          idx_next = idx + VIDX_W'(1);
        end
      end
      ST_FREE: begin
        if (!idx_busy) begin
          pick_next  = idx;
          idx_next   = '0;
          found_next = 1'b0;
          state_next = ST_LRU;
        end else if (idx == LAST_IDX) begin
          pick_next  = lru_head;
          idx_next   = '0;
          found_next = 1'b0;
          state_next = ST_LRU;
        end else begin
          idx_next = idx + VIDX_W'(1);
        end
      end
      ST_LRU: begin
        if (idx == LAST_IDX) begin
          lru_ctrl.put_en = 1'b1;
          state_next      = ST_DONE;
        end else begin
          // close up from the chosen channel's position onwards
          lru_ctrl.shift_en = found || cmp_eq;
          found_next        = found || cmp_eq;
          idx_next          = idx + VIDX_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          voice_wr.en    = 1'b1;
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
      found     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      idx       <= idx_next;
      found     <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    pick <= pick_next;
    if (accept) begin
      id_q   <= sound_id;
      busy_q <= channel_busy[BUSY_BITS-1:0];
      prio_q <= priority_req;
    end
    if (load_out) begin
      channel      <= CH_W'(pick) + CH_W'(1);
      sound_out    <= id_q;
      priority_out <= prio_q;
    end
  end

  `AVL_ASSERT_NOW(a_busy_not_ready, clk, rst, state != ST_IDLE, !in_ready, "ready while working")
  `AVL_ASSERT_NEXT(a_zero_id_dropped, clk, rst, accept && sound_id == '0,
                   state == ST_IDLE, "zero id started work")
  `AVL_ASSERT_NOW(a_result_nonzero, clk, rst, out_valid, sound_out != '0, "result with zero id")
  `AVL_ASSERT_NEXT(a_done_loads, clk, rst, state == ST_DONE && (!out_valid || out_ready),
                   out_valid && state == ST_IDLE, "finished item not delivered")

endmodule

`default_nettype wire
